// ===== rtl/particle_verlet_integrator_defines.svh =====
// assertion macros shared by the particle verlet integrator files
// no dependencies
`ifndef PARTICLE_VERLET_INTEGRATOR_DEFINES_SVH
`define PARTICLE_VERLET_INTEGRATOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PVI_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define PVI_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/pvi_pkg.sv =====
// package for the particle verlet integrator: types, codes and constants
// no dependencies
package pvi_pkg;

    localparam logic [2:0] FUNC_FULL     = 3'd0;
    localparam logic [2:0] FUNC_HALF     = 3'd1;
    localparam logic [2:0] FUNC_MOBILE   = 3'd2;
    localparam logic [2:0] FUNC_ADVECTED = 3'd3;
    localparam logic [2:0] FUNC_STATIC   = 3'd4;

    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_GRAVITY_X = 2'd1;
    localparam logic [1:0] REG_GRAVITY_Y = 2'd2;
    localparam logic [1:0] REG_GRAVITY_Z = 2'd3;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam int TIME_STEP_RESET = 655;
    localparam int GRAVITY_Z_RESET = -642908;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;

    // request and status between the sequencer and the divider
    typedef struct packed {
        logic                          start;
        logic signed [DIV_NUM_W-1:0]   num;
        logic        [DIV_DEN_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                          busy;
        logic                          done;
        logic signed [DIV_NUM_W-1:0]   quot;
    } div_stat_t;

    // saturate a 64 bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // saturate a 64 bit signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        if (x > 64'sd140737488355327)
            return 48'sh7fffffffffff;
        else if (x < -64'sd140737488355328)
            return 48'sh800000000000;
        else
            return x[47:0];
    endfunction

endpackage

// ===== rtl/pvi_ram.sv =====
// generic single port ram with registered read
// no dependencies
module pvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3072
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  addr,
    input  logic [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write first is not needed, plain read before write
    always_ff @(posedge aclk) begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/pvi_divider.sv =====
// signed restoring divider, one quotient bit per cycle, truncating toward zero
// depends on pvi_pkg and the defines header
`include "particle_verlet_integrator_defines.svh"
module pvi_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  pvi_pkg::div_req_t   req,
    output pvi_pkg::div_stat_t  stat
);
    localparam int NW = pvi_pkg::DIV_NUM_W;
    localparam int DW = pvi_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   trial;
    logic [NW-1:0] mag;

    assign mag   = req.num[NW-1] ? (~req.num + 1'b1) : req.num;
    assign trial = {rem_reg[DW-1:0], q_reg[NW-1]} - {1'b0, den_reg};

    // one shift and subtract step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            neg_next  = req.num[NW-1];
            q_next    = mag;
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DW-1:0], q_reg[NW-1]};
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = neg_reg ? $signed(~q_reg + 1'b1) : $signed(q_reg);

    `PVI_ASSERT_NEXT(a_done_after_busy, aclk, aresetn, stat.done, !stat.busy,
        "divider done while busy")
    `PVI_ASSERT_IMPL(a_cnt_zero_idle, aclk, aresetn, !busy_reg, cnt_reg == CW'(0),
        "divider count not zero while idle")
    `PVI_ASSERT_NEXT(a_busy_last, aclk, aresetn, busy_reg && cnt_reg == CW'(1), stat.done,
        "divider did not finish")
endmodule

// ===== rtl/particle_verlet_integrator.sv =====
// top level of the particle verlet integrator: sequencer, shared multiplier, tables
// depends on pvi_pkg, pvi_divider, pvi_ram and the defines header
`include "particle_verlet_integrator_defines.svh"

// One word per particle axis in, one word out; func and axis travel on s_tuser and the
// last particle flag on s_tlast. A static word goes straight to the output, an advected
// word reads the average tables before its position update, and a full, half or mobile
// step multiplies gravity by dt and makes two divider runs before velocity and position.
// The shared signed divider retires one quotient bit per cycle over 64 bits, for F*dt/m
// and T*dt/I, and twice more for the two averages at a mobile cell's last particle. The
// result is held until taken and no new word is accepted meanwhile. After reset the average
// tables are cleared one entry a cycle over all 3*MAX_CELLS entries, and no word is taken.
module particle_verlet_integrator #(
    parameter int MAX_CELLS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // fields from bit 0: cell_index[9:0], position[41:10], velocity[73:42],
    // angular_velocity[105:74], force_req[137:106], torque[169:138],
    // mass[200:170], inertia[231:201]
    input  logic [231:0] s_tdata,
    // fields from bit 0: func[2:0], axis[4:3]
    input  logic [4:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         s_tvalid,
    output logic         s_tready,
    // fields from bit 0: new_position, new_velocity, new_angular_velocity
    output logic [95:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    localparam int DEPTH = MAX_CELLS * 3;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DTG   = 4'd2;
    localparam logic [3:0] ST_FDM   = 4'd3;
    localparam logic [3:0] ST_TDI   = 4'd4;
    localparam logic [3:0] ST_VEL   = 4'd5;
    localparam logic [3:0] ST_POS   = 4'd6;
    localparam logic [3:0] ST_SUMS  = 4'd7;
    localparam logic [3:0] ST_AVV   = 4'd8;
    localparam logic [3:0] ST_AVA   = 4'd9;
    localparam logic [3:0] ST_RD    = 4'd10;
    localparam logic [3:0] ST_ADV   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;
    localparam logic [3:0] ST_WAIT  = 4'd13;

    // configuration
    logic        [30:0] dt_reg;
    logic signed [31:0] gx_reg, gy_reg, gz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= 31'(pvi_pkg::TIME_STEP_RESET);
            gx_reg <= '0;
            gy_reg <= '0;
            gz_reg <= 32'(pvi_pkg::GRAVITY_Z_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                pvi_pkg::REG_TIME_STEP: dt_reg <= cfg_wdata[30:0];
                pvi_pkg::REG_GRAVITY_X: gx_reg <= cfg_wdata;
                pvi_pkg::REG_GRAVITY_Y: gy_reg <= cfg_wdata;
                pvi_pkg::REG_GRAVITY_Z: gz_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured item
    logic        [2:0]  func_reg;
    logic        [9:0]  cell_reg;
    logic        [1:0]  axis_reg;
    logic               last_reg;
    logic signed [31:0] x_reg, v_reg, w_reg, f_reg, t_reg;
    logic        [30:0] m_reg, i_reg;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic        div_wait_reg;

    // working values
    logic signed [63:0] dtg_reg, fdm_reg, tdi_reg;
    logic signed [31:0] acc_reg, nv_reg, nw_reg, nx_reg;
    logic signed [47:0] vsum_reg [3];
    logic signed [47:0] asum_reg [3];
    logic        [15:0] cnt_reg [3];
    logic signed [47:0] sv_reg, sa_reg;
    logic        [15:0] n_reg;
    logic signed [31:0] avv_reg;
    logic        [95:0] out_reg;
    logic               out_valid_reg;

    logic signed [31:0] grav;
    logic               cell_ok;
    logic [AW-1:0]      ti;
    logic               is_step;

    always_comb begin
        case (axis_reg)
            pvi_pkg::AXIS_X: grav = gx_reg;
            pvi_pkg::AXIS_Y: grav = gy_reg;
            pvi_pkg::AXIS_Z: grav = gz_reg;
            default:         grav = '0;
        endcase
    end

    assign cell_ok = (32'(cell_reg) < 32'(MAX_CELLS)) && (axis_reg != pvi_pkg::AXIS_NONE);
    assign ti      = AW'(32'(cell_reg) * 3 + 32'(axis_reg));
    assign is_step = s_tuser[2:0] <= pvi_pkg::FUNC_MOBILE;

    // shared multiplier, 32 by 32 signed: dt times an operand picked by the sequencer
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    always_comb begin
        mul_a = $signed({1'b0, dt_reg});
        case (state_reg)
            ST_DTG:  mul_b = grav;
            ST_FDM:  mul_b = f_reg;
            ST_TDI:  mul_b = t_reg;
            default: mul_b = nv_reg;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider
    pvi_pkg::div_req_t  dreq;
    pvi_pkg::div_stat_t dstat;
    pvi_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .stat(dstat));

    always_comb begin
        dreq.start = 1'b0;
        dreq.num   = mul_p;
        dreq.den   = 32'd1;
        case (state_reg)
            ST_FDM: begin
                dreq.start = !div_wait_reg;
                dreq.den   = (m_reg == '0) ? 32'd1 : {1'b0, m_reg};
            end
            ST_TDI: begin
                dreq.start = !div_wait_reg;
                dreq.den   = (i_reg == '0) ? 32'd1 : {1'b0, i_reg};
            end
            ST_AVV: begin
                dreq.start = !div_wait_reg;
                dreq.num   = 64'(sv_reg);
                dreq.den   = {16'd0, n_reg};
            end
            ST_AVA: begin
                dreq.start = !div_wait_reg;
                dreq.num   = 64'(sa_reg);
                dreq.den   = {16'd0, n_reg};
            end
            default: ;
        endcase
    end

    // average tables
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ramv_wd, rama_wd, ramv_rd, rama_rd;
    logic          rama_we;

    pvi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_avg_vel (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ramv_wd), .rdata(ramv_rd));
    pvi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_avg_acc (
        .aclk(aclk), .we(rama_we), .addr(ram_addr), .wdata(rama_wd), .rdata(rama_rd));

    // table values arrive in the cycle after the read address
    logic signed [31:0] tvr, tar;
    assign tvr = cell_ok ? ramv_rd : '0;
    assign tar = cell_ok ? rama_rd : '0;

    logic signed [63:0] va_sum;
    logic signed [31:0] va;
    assign va_sum = 64'(tvr) + 64'(tar);
    assign va     = pvi_pkg::sat32(va_sum);

    always_comb begin
        ram_addr = (state_reg == ST_CLEAR) ? clr_reg : ti;
        ram_we   = 1'b0;
        rama_we  = 1'b0;
        ramv_wd  = '0;
        rama_wd  = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we  = 1'b1;
                rama_we = 1'b1;
            end
            ST_AVA: if (dstat.done && cell_ok) begin
                ram_we  = 1'b1;
                rama_we = 1'b1;
                ramv_wd = avv_reg;
                rama_wd = pvi_pkg::sat32(dstat.quot);
            end
            ST_ADV: if (cell_ok) begin
                ram_we  = 1'b1;
                ramv_wd = va;
            end
            default: ;
        endcase
    end

    // sequencer
    logic signed [63:0] acc_full, tdi_h, acc_h;
    logic signed [31:0] nv_c, nw_c, acc_c, tdi_c;
    always_comb begin
        acc_full = dtg_reg + fdm_reg;
        acc_h    = (func_reg == pvi_pkg::FUNC_HALF) ? (acc_full >>> 1) : acc_full;
        tdi_h    = (func_reg == pvi_pkg::FUNC_HALF) ? (tdi_reg >>> 1) : tdi_reg;
        acc_c    = pvi_pkg::sat32(acc_h);
        tdi_c    = pvi_pkg::sat32(tdi_h);
        nv_c     = pvi_pkg::sat32(64'(v_reg) + 64'(acc_c));
        nw_c     = pvi_pkg::sat32(64'(w_reg) + 64'(tdi_c));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid)
                state_next = is_step ? ST_DTG
                           : (s_tuser[2:0] == pvi_pkg::FUNC_ADVECTED) ? ST_RD : ST_OUT;
            ST_DTG:  state_next = ST_FDM;
            ST_FDM:  if (dstat.done) state_next = ST_TDI;
            ST_TDI:  if (dstat.done) state_next = ST_VEL;
            ST_VEL:  state_next = ST_POS;
            ST_POS:  state_next = (func_reg == pvi_pkg::FUNC_MOBILE
                                   && axis_reg != pvi_pkg::AXIS_NONE) ? ST_SUMS : ST_OUT;
            ST_SUMS: state_next = last_reg ? ST_AVV : ST_OUT;
            ST_AVV:  if (dstat.done) state_next = ST_AVA;
            ST_AVA:  if (dstat.done) state_next = ST_OUT;
            ST_RD:   state_next = ST_ADV;
            ST_ADV:  state_next = ST_POS;
            ST_OUT:  state_next = ST_WAIT;
            ST_WAIT: if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    logic [1:0] ax;
    assign ax = axis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            div_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                vsum_reg[k] <= '0;
                asum_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (dstat.done)
                div_wait_reg <= 1'b0;
            else if (dreq.start)
                div_wait_reg <= 1'b1;
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            else if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            // per-axis running sums
            if (state_reg == ST_SUMS) begin
                if (last_reg) begin
                    vsum_reg[ax] <= '0;
                    asum_reg[ax] <= '0;
                    cnt_reg[ax]  <= '0;
                end else begin
                    vsum_reg[ax] <= pvi_pkg::sat48(64'(vsum_reg[ax]) + 64'(nv_reg));
                    asum_reg[ax] <= pvi_pkg::sat48(64'(asum_reg[ax]) + 64'(acc_reg));
                    if (cnt_reg[ax] != 16'hffff)
                        cnt_reg[ax] <= cnt_reg[ax] + 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            func_reg <= s_tuser[2:0];
            axis_reg <= s_tuser[4:3];
            last_reg <= s_tlast;
            cell_reg <= s_tdata[9:0];
            x_reg    <= s_tdata[41:10];
            v_reg    <= s_tdata[73:42];
            w_reg    <= s_tdata[105:74];
            f_reg    <= s_tdata[137:106];
            t_reg    <= s_tdata[169:138];
            m_reg    <= s_tdata[200:170];
            i_reg    <= s_tdata[231:201];
            nv_reg   <= s_tdata[73:42];
            nw_reg   <= s_tdata[105:74];
            nx_reg   <= s_tdata[41:10];
        end
        case (state_reg)
            ST_DTG: dtg_reg <= mul_p >>> FRAC_BITS;
            ST_FDM: if (dstat.done) fdm_reg <= dstat.quot;
            ST_TDI: if (dstat.done) tdi_reg <= dstat.quot;
            ST_VEL: begin
                acc_reg <= acc_c;
                nv_reg  <= nv_c;
                nw_reg  <= nw_c;
            end
            ST_POS: nx_reg <= pvi_pkg::sat32(64'(x_reg) + (mul_p >>> FRAC_BITS));
            ST_SUMS: begin
                sv_reg <= pvi_pkg::sat48(64'(vsum_reg[ax]) + 64'(nv_reg));
                sa_reg <= pvi_pkg::sat48(64'(asum_reg[ax]) + 64'(acc_reg));
                n_reg  <= (cnt_reg[ax] != 16'hffff) ? cnt_reg[ax] + 1'b1 : cnt_reg[ax];
            end
            ST_AVV: if (dstat.done) avv_reg <= pvi_pkg::sat32(dstat.quot);
            // advected velocity drives the position update
            ST_ADV: nv_reg <= va;
            default: ;
        endcase
        if (state_reg == ST_OUT)
            out_reg <= {nw_reg, nv_reg, nx_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = (func_reg == pvi_pkg::FUNC_ADVECTED)
                    ? {w_reg, v_reg, out_reg[31:0]} : out_reg;

    `PVI_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready,
        "ready outside idle")
    `PVI_ASSERT_NEXT(a_out_on_done, aclk, aresetn, state_reg == ST_OUT, m_tvalid,
        "result not presented")
    `PVI_ASSERT_IMPL(a_no_accept_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_tready,
        "word taken during clear")
endmodule

// ===== test/particle_verlet_integrator_test.sv =====
// regression bench for the particle verlet integrator: table-driven and random words
// depends on pvi_pkg and the particle_verlet_integrator top level
`timescale 1ns / 100ps

module particle_verlet_integrator_test;

    localparam int CELLS     = 1024;
    localparam int FRAC      = 16;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [30:0]        inertia;
        logic [30:0]        mass;
        logic signed [31:0] torque;
        logic signed [31:0] force_req;
        logic signed [31:0] angular_velocity;
        logic signed [31:0] velocity;
        logic signed [31:0] position;
        logic               last_in_cell;
        logic [1:0]         axis;
        logic [9:0]         cell_index;
        logic [2:0]         func;
    } particle_word_t;

    typedef struct packed {
        logic signed [31:0] new_angular_velocity;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_position;
    } update_word_t;

    // directed row: stimulus plus an optional typed-in answer
    typedef struct {
        particle_word_t pw;
        bit             has_exp;
        update_word_t   exp_w;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [231:0] s_tdata = '0;
    logic [4:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    particle_verlet_integrator #(.MAX_CELLS(CELLS), .FRAC_BITS(FRAC)) i_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // integrator state mirror
    longint unsigned   dt_q;
    longint            grav_q[3];
    int                avg_vel_tab[CELLS*3];
    int                avg_acc_tab[CELLS*3];
    longint            vel_acc_sum[3];
    longint            step_acc_sum[3];
    int                part_count[3];

    update_word_t      pending_updates[$];
    int                mismatches = 0;
    bit                hold_off = 1'b0;
    bit                stim_done = 1'b0;

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clamp48(longint x);
        if (x > 64'sd140737488355327) return 64'sd140737488355327;
        if (x < -64'sd140737488355328) return -64'sd140737488355328;
        return x;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // compute the update for one particle word and advance the mirror
    function automatic update_word_t integrate(particle_word_t p);
        update_word_t u;
        longint dt, g, m, inr, x, v, w, dtg, fdm, tdi, acc, nx, nv, nw, va, n;
        bit ok;
        int ti;
        dt = longint'(dt_q);
        x = p.position; v = p.velocity; w = p.angular_velocity;
        nx = x; nv = v; nw = w;
        m = (p.mass == 0) ? 1 : longint'(p.mass);
        inr = (p.inertia == 0) ? 1 : longint'(p.inertia);
        g = (p.axis == pvi_pkg::AXIS_NONE) ? 0 : grav_q[p.axis];
        ok = (p.cell_index < CELLS) && (p.axis != pvi_pkg::AXIS_NONE);
        ti = int'(p.cell_index) * 3 + int'(p.axis);
        if (p.func <= pvi_pkg::FUNC_MOBILE) begin
            dtg = floor_shift(dt * g, FRAC);
            fdm = (longint'(p.force_req) * dt) / m;
            tdi = (longint'(p.torque) * dt) / inr;
            acc = dtg + fdm;
            if (p.func == pvi_pkg::FUNC_HALF) begin
                acc = acc >>> 1;
                tdi = tdi >>> 1;
            end
            acc = clamp32(acc);
            tdi = clamp32(tdi);
            nv = clamp32(v + acc);
            nw = clamp32(w + tdi);
            nx = clamp32(x + floor_shift(nv * dt, FRAC));
            if (p.func == pvi_pkg::FUNC_MOBILE && p.axis != pvi_pkg::AXIS_NONE) begin
                vel_acc_sum[p.axis] = clamp48(vel_acc_sum[p.axis] + nv);
                step_acc_sum[p.axis] = clamp48(step_acc_sum[p.axis] + acc);
                if (part_count[p.axis] < 65535) part_count[p.axis]++;
                if (p.last_in_cell) begin
                    n = part_count[p.axis];
                    if (ok) begin
                        avg_vel_tab[ti] = int'(clamp32(vel_acc_sum[p.axis] / n));
                        avg_acc_tab[ti] = int'(clamp32(step_acc_sum[p.axis] / n));
                    end
                    vel_acc_sum[p.axis] = 0;
                    step_acc_sum[p.axis] = 0;
                    part_count[p.axis] = 0;
                end
            end
        end else if (p.func == pvi_pkg::FUNC_ADVECTED) begin
            va = 0;
            if (ok) begin
                va = clamp32(longint'(avg_vel_tab[ti]) + longint'(avg_acc_tab[ti]));
                avg_vel_tab[ti] = int'(va);
            end
            nx = clamp32(x + floor_shift(va * dt, FRAC));
        end
        u.new_position = nx[31:0];
        u.new_velocity = nv[31:0];
        u.new_angular_velocity = nw[31:0];
        return u;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            pvi_pkg::REG_TIME_STEP: dt_q = {33'd0, val[30:0]};
            pvi_pkg::REG_GRAVITY_X: grav_q[0] = longint'($signed(val));
            pvi_pkg::REG_GRAVITY_Y: grav_q[1] = longint'($signed(val));
            default:                grav_q[2] = longint'($signed(val));
        endcase
    endtask

    task automatic wait_drained();
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // present one word; valid stays high across back-to-back words
    task automatic send_word(input particle_word_t p, input bit has_exp,
                             input update_word_t exp_w);
        update_word_t pred;
        s_tdata <= {p.inertia, p.mass, p.torque, p.force_req, p.angular_velocity,
                    p.velocity, p.position, p.cell_index};
        s_tuser <= {p.axis, p.func};
        s_tlast <= p.last_in_cell;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = integrate(p);
        if (has_exp && pred !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
                $display("typed answer differs from prediction: %h vs %h", exp_w, pred);
        end
        pending_updates.push_back(pred);
    endtask

    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_edge32();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_word_t rand_word(input logic [2:0] f, input logic [9:0] c,
                                                 input logic [1:0] ax, input bit last);
        particle_word_t p;
        p.func = f; p.cell_index = c; p.axis = ax; p.last_in_cell = last;
        p.position = rand_edge32();
        p.velocity = ($urandom_range(0, 3) == 0) ? rand_edge32()
                                                 : $urandom_range(0, 2000000) - 1000000;
        p.angular_velocity = rand_edge32();
        p.force_req = rand_edge32();
        p.torque = rand_edge32();
        p.mass = ($urandom_range(0, 7) == 0) ? 31'(rand_edge32()) : 31'($urandom);
        p.inertia = ($urandom_range(0, 7) == 0) ? 31'(rand_edge32()) : 31'($urandom);
        return p;
    endfunction

    // result checker
    always @(posedge aclk) begin
        update_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = pending_updates.pop_front();
                if (got.new_position !== want.new_position
                        || got.new_velocity !== want.new_velocity
                        || got.new_angular_velocity !== want.new_angular_velocity) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x %h v %h w %h, got x %h v %h w %h",
                                 want.new_position, want.new_velocity,
                                 want.new_angular_velocity, got.new_position,
                                 got.new_velocity, got.new_angular_velocity);
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge aclk) begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 9) < 7) || stim_done;
    end

    initial begin
        #20000000;
        $display("particle_verlet_integrator regression: fail");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t r;
        particle_word_t p;
        update_word_t none;
        logic [2:0] f;
        logic [9:0] c;
        logic [1:0] ax;
        int sent, burst, cnt;

        dt_q = pvi_pkg::TIME_STEP_RESET;
        grav_q[0] = 0; grav_q[1] = 0; grav_q[2] = pvi_pkg::GRAVITY_Z_RESET;
        foreach (avg_vel_tab[i]) begin
            avg_vel_tab[i] = 0;
            avg_acc_tab[i] = 0;
        end
        for (int a = 0; a < 3; a++) begin
            vel_acc_sum[a] = 0; step_acc_sum[a] = 0; part_count[a] = 0;
        end
        none = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows
        p = '0; p.func = pvi_pkg::FUNC_STATIC; p.position = 32'h7fffffff;
        p.velocity = 32'h80000000; p.angular_velocity = 32'h12345678;
        r.pw = p; r.has_exp = 1; r.exp_w = {32'h12345678, 32'h80000000, 32'h7fffffff};
        rows.push_back(r);
        p.func = 3'd7; r.pw = p; rows.push_back(r);
        p = '0; p.func = pvi_pkg::FUNC_ADVECTED; p.cell_index = 10'd5; p.position = 32'h100;
        r.pw = p; r.exp_w = {32'h0, 32'h0, 32'h100}; rows.push_back(r);
        r.has_exp = 0;
        p = rand_word(pvi_pkg::FUNC_FULL, 0, pvi_pkg::AXIS_Z, 0); p.mass = 0; p.inertia = 0;
        r.pw = p; rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_HALF, 0, pvi_pkg::AXIS_Z, 1); r.pw = p; rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_FULL, 0, pvi_pkg::AXIS_NONE, 0); r.pw = p;
        rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_FULL, 0, pvi_pkg::AXIS_X, 0); p.force_req = 32'h7fffffff;
        p.mass = 31'd1; p.velocity = 32'h7fffffff; r.pw = p; rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_HALF, 0, pvi_pkg::AXIS_Y, 0); p.torque = 32'h80000000;
        p.inertia = 31'd1; r.pw = p; rows.push_back(r);
        p.mass = 31'h7fffffff; p.inertia = 31'h7fffffff; r.pw = p; rows.push_back(r);
        for (int k = 0; k < 3; k++) begin
            p = rand_word(pvi_pkg::FUNC_MOBILE, 10'd7, pvi_pkg::AXIS_Y, k == 2);
            r.pw = p; rows.push_back(r);
        end
        p = rand_word(pvi_pkg::FUNC_ADVECTED, 10'd7, pvi_pkg::AXIS_Y, 0); r.pw = p;
        rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_ADVECTED, 10'd7, pvi_pkg::AXIS_Y, 1); r.pw = p;
        rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_MOBILE, 10'd1023, pvi_pkg::AXIS_NONE, 1); r.pw = p;
        rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_MOBILE, 10'd1023, pvi_pkg::AXIS_X, 1); r.pw = p;
        rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_ADVECTED, 10'd1023, pvi_pkg::AXIS_X, 0); r.pw = p;
        rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_FULL, 10'd3, pvi_pkg::AXIS_Z, 1); r.pw = p;
        rows.push_back(r);
        p = rand_word(pvi_pkg::FUNC_STATIC, 10'h3ff, pvi_pkg::AXIS_NONE, 1);
        p.mass = 31'h7fffffff; p.inertia = 31'h7fffffff; r.pw = p; rows.push_back(r);

        foreach (rows[i]) send_word(rows[i].pw, rows[i].has_exp, rows[i].exp_w);
        idle_cycles(1);

        // several register settings, extremes included
        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(pvi_pkg::REG_TIME_STEP, 32'd1);
                    write_reg(pvi_pkg::REG_GRAVITY_X, 32'h7fffffff);
                    write_reg(pvi_pkg::REG_GRAVITY_Y, 32'h80000000);
                    write_reg(pvi_pkg::REG_GRAVITY_Z, 32'd0);
                end
                1: begin
                    write_reg(pvi_pkg::REG_TIME_STEP, 32'h7fffffff);
                    write_reg(pvi_pkg::REG_GRAVITY_X, 32'h80000000);
                    write_reg(pvi_pkg::REG_GRAVITY_Y, 32'h7fffffff);
                    write_reg(pvi_pkg::REG_GRAVITY_Z, 32'hffffffff);
                end
                2: write_reg(pvi_pkg::REG_TIME_STEP, 32'd0);
                default: begin
                    write_reg(pvi_pkg::REG_TIME_STEP,
                              {1'b0, 31'($urandom_range(1, 1 << 18))});
                    write_reg(pvi_pkg::REG_GRAVITY_X, $urandom_range(0, 2000000) - 1000000);
                    write_reg(pvi_pkg::REG_GRAVITY_Y, $urandom_range(0, 2000000) - 1000000);
                    write_reg(pvi_pkg::REG_GRAVITY_Z, $urandom);
                end
            endcase

            // long receiver hold-off while words keep being offered
            if (phase == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end

            cnt = 0;
            while (cnt < 280) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++) begin
                    // mostly well-formed cell runs over one axis, otherwise noise
                    if ($urandom_range(0, 9) < 7) begin
                        c = ($urandom_range(0, 3) == 0) ? 10'(1023 - $urandom_range(0, 3))
                                                        : 10'($urandom_range(0, 15));
                        ax = 2'($urandom_range(0, 2));
                        for (int k = $urandom_range(1, 4); k > 0; k--) begin
                            send_word(rand_word(pvi_pkg::FUNC_MOBILE, c, ax, k == 1),
                                      0, none);
                            cnt++;
                        end
                        send_word(rand_word(pvi_pkg::FUNC_ADVECTED, c, ax,
                                            $urandom_range(0, 1)), 0, none);
                        cnt++;
                    end else begin
                        f = 3'($urandom_range(0, 7));
                        send_word(rand_word(f, 10'($urandom), 2'($urandom),
                                            $urandom_range(0, 1)), 0, none);
                        cnt++;
                    end
                end
                if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 300));
            end
            idle_cycles(1);
            // sender pause in phase 4 until everything has come back
            if (phase == 4) while (pending_updates.size() != 0) @(posedge aclk);
            sent += cnt;
        end

        stim_done = 1'b1;
        wait_drained();
        if (mismatches == 0)
            $display("particle_verlet_integrator regression: pass");
        else
            $display("particle_verlet_integrator regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pvi_pkg.sv
rtl/pvi_ram.sv
rtl/pvi_divider.sv
rtl/particle_verlet_integrator.sv
test/particle_verlet_integrator_test.sv
